/* sv/cgts_pkg.sv */
// ----------------------------------------------------------------------------
// cgts_pkg: shared types and constants of the coarse-grained thread selector
// Field widths, register indexes, controller states, the command and status
// bundles between controller and datapath, and a saturating time adder.
// ----------------------------------------------------------------------------
package cgts_pkg;

  localparam int unsigned MaxThreads = 8;
  localparam int unsigned ThreadW    = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int unsigned TotalW     = $clog2(MaxThreads + 1);

  localparam int unsigned ThreadIdW = 3;
  localparam int unsigned ItemW     = 16;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned CycW      = 16;
  localparam int unsigned LimitW    = 4;
  localparam int unsigned CostW     = 8;

  // Divider works on item_count + threads - 1, one quotient bit per cycle.
  localparam int unsigned DivW = ItemW + 1;
  localparam int unsigned CntW = $clog2(DivW);
  // Chunk start of the last thread and chunk end.
  localparam int unsigned AccW = ItemW + ThreadW;
  localparam int unsigned EndW = AccW + 1;

  localparam int unsigned InDataW    = ((TimeW + 2 * CycW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = ThreadIdW + ItemW + 2 * TimeW + 1;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic CmdStart  = 1'b0;
  localparam logic CmdReport = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THREAD_LIMIT = 2'd0,
    CFG_ITEM_COUNT   = 2'd1,
    CFG_SWITCH_COST  = 2'd2,
    CFG_CYCLE_MODEL  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILL,
    ST_REP_A,
    ST_REP_B,
    ST_SEL,
    ST_MIN,
    ST_WAKE,
    ST_COMMIT,
    ST_EMIT
  } cgts_state_e;

  typedef struct packed {
    logic accept;
    logic start_init;
    logic div_step;
    logic fill_step;
    logic rep_time;
    logic rep_item;
    logic sel_latch;
    logic set_done;
    logic min_step;
    logic wake_apply;
    logic commit;
    logic emit_load;
  } cgts_cmd_t;

  typedef struct packed {
    logic div_last;
    logic idx_last;
    logic any_items;
    logic found;
    logic out_free;
  } cgts_status_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

/* sv/cgts_ctrl.sv */
// ----------------------------------------------------------------------------
// cgts_ctrl: sequencer of the thread selector
// Walks one request through divide, fill, report update, selection, wake
// search, commit and result hand-off, and tells the datapath what to do.
// ----------------------------------------------------------------------------
module cgts_ctrl
  import cgts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_cmd_i,
  input  cgts_status_t status_i,
  output logic         s_ready_o,
  output cgts_cmd_t    cmd_o
);

  cgts_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = (s_cmd_i == CmdStart) ? ST_DIV : ST_REP_A;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.idx_last) state_d = ST_SEL;
      end
      ST_REP_A: state_d = ST_REP_B;
      ST_REP_B: state_d = ST_SEL;
      ST_SEL: begin
        if (!status_i.any_items) begin
          state_d = ST_EMIT;
        end else if (status_i.found) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        if (status_i.idx_last) state_d = ST_WAKE;
      end
      ST_WAKE:   state_d = ST_SEL;
      ST_COMMIT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o        = 1'b1;
        cmd_o.accept     = s_valid_i;
        cmd_o.start_init = s_valid_i && (s_cmd_i == CmdStart);
      end
      ST_DIV:    cmd_o.div_step   = 1'b1;
      ST_FILL:   cmd_o.fill_step  = 1'b1;
      ST_REP_A:  cmd_o.rep_time   = 1'b1;
      ST_REP_B:  cmd_o.rep_item   = 1'b1;
      ST_SEL: begin
        cmd_o.sel_latch = 1'b1;
        cmd_o.set_done  = !status_i.any_items;
      end
      ST_MIN:    cmd_o.min_step   = 1'b1;
      ST_WAKE:   cmd_o.wake_apply = 1'b1;
      ST_COMMIT: cmd_o.commit     = 1'b1;
      ST_EMIT:   cmd_o.emit_load  = status_i.out_free;
      default: begin
        cmd_o     = '0;
        s_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* sv/cgts_dp.sv */
// ----------------------------------------------------------------------------
// cgts_dp: datapath of the thread selector
// Configuration registers, per-thread item ranges and wake times, the chunk
// divider, the runnable scan, the wake minimum sweep and the result register.
// ----------------------------------------------------------------------------
module cgts_dp
  import cgts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cgts_cmd_t           cmd_i,
  output cgts_status_t        status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic                m_ready_i,
  output logic                m_valid_o,
  output logic [OutDataW-1:0] m_data_o,
  output logic                m_user_o
);

  // Configuration.
  logic [LimitW-1:0] limit_q, limit_d;
  logic [ItemW-1:0]  count_q, count_d;
  logic [CostW-1:0]  cost_q, cost_d;
  logic              cme_q, cme_d;

  // Per-thread state.
  logic [ItemW-1:0] next_q [MaxThreads];
  logic [ItemW-1:0] next_d [MaxThreads];
  logic [ItemW-1:0] end_q  [MaxThreads];
  logic [ItemW-1:0] end_d  [MaxThreads];
  logic [TimeW-1:0] wake_q [MaxThreads];
  logic [TimeW-1:0] wake_d [MaxThreads];

  // Selector state.
  logic [TimeW-1:0]  time_q, time_d;
  logic [ThreadW-1:0] cur_q, cur_d;
  logic              hc_q, hc_d;
  logic [TotalW-1:0] total_q, total_d;

  // Per-request working registers.
  logic [CycW-1:0]    cyc_q, cyc_d;
  logic [CycW-1:0]    lat_q, lat_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [TotalW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [ThreadW-1:0] idx_q, idx_d;
  logic [ThreadW-1:0] chosen_q, chosen_d;
  logic [TimeW-1:0]   min_q, min_d;
  logic [TimeW-1:0]   idle_q, idle_d;
  logic               sw_q, sw_d;
  logic               done_q, done_d;

  // Result register.
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic                m_user_q, m_user_d;

  logic [MaxThreads-1:0] has_items;
  logic [MaxThreads-1:0] runnable;
  logic                  keep_cur;
  logic                  scan_hit;
  logic [ThreadW-1:0]    scan_pos;
  logic [ThreadW-1:0]    chosen;
  logic [TotalW-1:0]     tt;
  logic                  rep_ok;

  assign cfg_ready_o = 1'b1;

  // Each thread lane checks its own range and wake time.
  always_comb begin
    for (int t = 0; t < MaxThreads; t++) begin
      has_items[t] = next_q[t] < end_q[t];
      runnable[t]  = has_items[t] && (time_q >= wake_q[t]);
    end
  end

  // Round-robin scan starting after the current thread, or at lane 0 when
  // there is none. Lanes past the thread total never hold items, so wrapping
  // at the lane count matches wrapping at the total.
  always_comb begin
    logic [ThreadW-1:0]      first;
    logic [2*MaxThreads-1:0] dbl;
    logic [ThreadW-1:0]      off;
    logic [ThreadW:0]        pos;
    first = '0;
    if (hc_q) begin
      first = (cur_q == ThreadW'(MaxThreads - 1)) ? '0 : ThreadW'(cur_q + 1'b1);
    end
    dbl      = {runnable, runnable} >> first;
    off      = '0;
    scan_hit = 1'b0;
    for (int k = MaxThreads - 1; k >= 0; k--) begin
      if (dbl[k]) begin
        scan_hit = 1'b1;
        off      = ThreadW'(k);
      end
    end
    pos = {1'b0, first} + {1'b0, off};
    if (pos >= (ThreadW + 1)'(MaxThreads)) pos = pos - (ThreadW + 1)'(MaxThreads);
    scan_pos = pos[ThreadW-1:0];
  end

  assign keep_cur = hc_q && (TotalW'(cur_q) < total_q) && runnable[cur_q];
  assign chosen   = keep_cur ? cur_q : scan_pos;
  assign rep_ok   = hc_q && (TotalW'(cur_q) < total_q);

  // Thread total: max(1, min(limit, count, lanes)).
  always_comb begin
    logic [TotalW-1:0] t1;
    if (ItemW'(limit_q) > count_q) begin
      t1 = (count_q > ItemW'(MaxThreads)) ? TotalW'(MaxThreads) : TotalW'(count_q);
    end else begin
      t1 = (limit_q > LimitW'(MaxThreads)) ? TotalW'(MaxThreads) : TotalW'(limit_q);
    end
    tt = (t1 == '0) ? TotalW'(1) : t1;
  end

  assign status_o.div_last  = cnt_q == CntW'(DivW - 1);
  assign status_o.idx_last  = idx_q == ThreadW'(MaxThreads - 1);
  assign status_o.any_items = |has_items;
  assign status_o.found     = keep_cur || scan_hit;
  assign status_o.out_free  = !m_valid_q || m_ready_i;

  always_comb begin
    logic [TotalW:0]  trial;
    logic [ItemW-1:0] chunk;
    logic [EndW-1:0]  e_end;
    logic [EndW-1:0]  e_beg;
    logic [ItemW:0]   nn;
    logic [ItemW-1:0] nx;
    logic [TimeW-1:0] t_new;

    limit_d = limit_q;
    count_d = count_q;
    cost_d  = cost_q;
    cme_d   = cme_q;
    next_d  = next_q;
    end_d   = end_q;
    wake_d  = wake_q;
    time_d  = time_q;
    cur_d   = cur_q;
    hc_d    = hc_q;
    total_d = total_q;
    cyc_d   = cyc_q;
    lat_d   = lat_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    chosen_d = chosen_q;
    min_d   = min_q;
    idle_d  = idle_q;
    sw_d    = sw_q;
    done_d  = done_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    trial = '0;
    chunk = quo_q[ItemW-1:0];
    e_end = '0;
    e_beg = '0;
    nn    = '0;
    nx    = next_q[cur_q];
    t_new = '0;

    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_THREAD_LIMIT: limit_d = cfg_data_i[LimitW-1:0];
        CFG_ITEM_COUNT:   count_d = cfg_data_i[ItemW-1:0];
        CFG_SWITCH_COST:  cost_d  = cfg_data_i[CostW-1:0];
        CFG_CYCLE_MODEL:  cme_d   = cfg_data_i[0];
        default:          cme_d   = cme_q;
      endcase
    end

    if (cmd_i.accept) begin
      cyc_d  = s_data_i[TimeW +: CycW];
      lat_d  = s_data_i[TimeW + CycW +: CycW];
      idle_d = '0;
      sw_d   = 1'b0;
    end

    if (cmd_i.start_init) begin
      time_d  = s_data_i[TimeW-1:0];
      cur_d   = '0;
      hc_d    = 1'b0;
      total_d = tt;
      quo_d   = DivW'(count_q) + DivW'(tt) - DivW'(1);
      rem_d   = '0;
      cnt_d   = '0;
      acc_d   = '0;
      idx_d   = '0;
    end

    // Restoring divider: ceiling chunk size.
    if (cmd_i.div_step) begin
      trial = {rem_q, quo_q[DivW-1]};
      if (trial >= (TotalW + 1)'(total_q)) begin
        trial = trial - (TotalW + 1)'(total_q);
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      rem_d = trial[TotalW-1:0];
      cnt_d = CntW'(cnt_q + 1'b1);
    end

    // One thread range a cycle.
    if (cmd_i.fill_step) begin
      e_beg = EndW'(acc_q);
      e_end = EndW'(acc_q) + EndW'(chunk);
      if (TotalW'(idx_q) >= total_q) begin
        e_beg = '0;
        e_end = '0;
      end
      if (e_end > EndW'(count_q)) e_end = EndW'(count_q);
      if (e_beg > e_end) e_beg = e_end;
      next_d[idx_q] = e_beg[ItemW-1:0];
      end_d[idx_q]  = e_end[ItemW-1:0];
      wake_d[idx_q] = '0;
      acc_d = AccW'(acc_q + AccW'(chunk));
      idx_d = ThreadW'(idx_q + 1'b1);
    end

    if (cmd_i.rep_time && rep_ok && cme_q) begin
      time_d = sat_add(time_q, TimeW'(cyc_q));
    end

    if (cmd_i.rep_item && rep_ok) begin
      if (cme_q && (lat_q != '0)) begin
        t_new = sat_add(time_q, TimeW'(lat_q));
        wake_d[cur_q] = t_new;
        hc_d = 1'b0;
      end
      nn = (nx < end_q[cur_q]) ? ({1'b0, nx} + (ItemW + 1)'(1)) : {1'b0, nx};
      next_d[cur_q] = nn[ItemW-1:0];
      if (nn >= {1'b0, end_q[cur_q]}) hc_d = 1'b0;
    end

    if (cmd_i.sel_latch) begin
      chosen_d = chosen;
      idx_d    = '0;
      min_d    = TimeMax;
    end

    if (cmd_i.set_done) begin
      hc_d   = 1'b0;
      done_d = 1'b1;
    end

    if (cmd_i.min_step) begin
      if (has_items[idx_q] && (wake_q[idx_q] < min_q)) min_d = wake_q[idx_q];
      idx_d = ThreadW'(idx_q + 1'b1);
    end

    // No thread was runnable: jump to the earliest wake.
    if (cmd_i.wake_apply) begin
      idle_d = min_q - time_q;
      time_d = min_q;
    end

    if (cmd_i.commit) begin
      if (hc_q && (chosen_q != cur_q)) begin
        time_d = sat_add(time_q, TimeW'(cost_q));
        sw_d   = 1'b1;
      end
      cur_d  = chosen_q;
      hc_d   = 1'b1;
      done_d = 1'b0;
    end

    if (cmd_i.emit_load) begin
      m_valid_d = 1'b1;
      m_user_d  = done_q;
      if (done_q) begin
        m_data_d = OutDataW'({{ItemW{1'b0}}, {ThreadIdW{1'b0}}});
        m_data_d[ThreadIdW + ItemW +: TimeW] = time_q;
      end else begin
        m_data_d = OutDataW'({sw_q, idle_q, time_q, next_q[cur_q], ThreadIdW'(cur_q)});
      end
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LimitW'(1);
      count_q   <= '0;
      cost_q    <= '0;
      cme_q     <= 1'b1;
      for (int t = 0; t < MaxThreads; t++) begin
        next_q[t] <= '0;
        end_q[t]  <= '0;
        wake_q[t] <= '0;
      end
      time_q    <= '0;
      cur_q     <= '0;
      hc_q      <= 1'b0;
      total_q   <= TotalW'(1);
      cnt_q     <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      limit_q   <= limit_d;
      count_q   <= count_d;
      cost_q    <= cost_d;
      cme_q     <= cme_d;
      next_q    <= next_d;
      end_q     <= end_d;
      wake_q    <= wake_d;
      time_q    <= time_d;
      cur_q     <= cur_d;
      hc_q      <= hc_d;
      total_q   <= total_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cyc_q    <= cyc_d;
    lat_q    <= lat_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    acc_q    <= acc_d;
    chosen_q <= chosen_d;
    min_q    <= min_d;
    idle_q   <= idle_d;
    sw_q     <= sw_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

endmodule

/* sv/coarse_grained_thread_select.sv */
// ----------------------------------------------------------------------------
// coarse_grained_thread_select: thread picker for switch-on-stall threading
// Splits a stage into per-thread chunks, issues items from the current thread
// while it stays runnable, switches round-robin on a stall and skips idle
// time to the earliest wake when every thread waits.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tuser: command
//                                                       tdata: time, cycles, stall
//   m_axis    out        m_axis_tvalid / m_axis_tready  tuser: done_res
//                                                       tdata: selection result
//   cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// A report request advances the time and the current thread's item, then runs
// the selection and the commit before its result is loaded. The commit is
// skipped when no thread has items left, and the wake sweep over the 8
// thread entries runs when every thread waits. A start request runs the
// bit-serial chunk divider and writes the thread ranges, then the selection.
// The next request is taken the cycle after the result is loaded; a new
// result waits while the result register is full. Reset puts every thread
// range and wake time at zero. The configuration port is always ready.
// ----------------------------------------------------------------------------
module coarse_grained_thread_select
  import cgts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [47:0] start_time, [63:48] compute_cycles, [79:64] stall_latency
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] command
  input  logic                s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] thread_id, [18:3] item_index, [66:19] now_time,
  // [114:67] idle_cycles, [115] switched, [119:116] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] done_res
  output logic                m_axis_tuser,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cgts_cmd_t    cmd;
  cgts_status_t status;

  cgts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_cmd_i   (s_axis_tuser),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  cgts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_data_i    (s_axis_tdata),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

/* sv/cgts_checker.sv */
// ----------------------------------------------------------------------------
// cgts_checker: port-level checks of the thread selector
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module cgts_checker
  import cgts_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A waiting result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A finished stage reports no thread, item, idle time or switch.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[18:0] == '0 && m_axis_tdata[114:67] == '0 && !m_axis_tdata[115])
    else $error("done result carries selection fields");

  // Only one request is worked on at a time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // A result never shows up in the cycle right after a request.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind coarse_grained_thread_select cgts_checker u_cgts_checker (.*);
